// ===== src/mci_pkg.sv =====
package mci_pkg;

    // Fixed field widths of the channels.
    localparam int TICK_BITS    = 32;
    localparam int CHANNEL_BITS = 4;
    localparam int PITCH_BITS   = 7;
    localparam int CLASS_BITS   = 12;
    localparam int ROOT_BITS    = 4;
    localparam int QUAL_BITS    = 4;

    // Defaults for the top-level parameters.
    localparam int TICK_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 8;

    localparam int NUM_CLASSES   = 12;
    localparam int NUM_TEMPLATES = 10;
    localparam int MIN_CLASSES   = 3;

    localparam logic [CHANNEL_BITS-1:0] DRUM_CHANNEL = 4'h9;

    // Event codes on the input channel.
    typedef enum logic [1:0] {
        ACT_NOTE_OFF = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_END      = 2'd2
    } t_action;

    localparam logic [QUAL_BITS-1:0] QUAL_NONE = 4'd0;

    // Chord templates in quality order, root at C.
    localparam logic [CLASS_BITS-1:0] CHORD_TEMPLATES [NUM_TEMPLATES] = '{
        12'h091,  // major
        12'h089,  // minor
        12'h049,  // diminished
        12'h111,  // augmented
        12'h491,  // dominant seventh
        12'h489,  // minor seventh
        12'h891,  // major seventh
        12'h889,  // minor-major seventh
        12'h449,  // half-diminished seventh
        12'h249   // diminished seventh
    };

    // A closed chord on its way to the matcher.
    typedef struct packed {
        logic [TICK_BITS-1:0]  chord_tick;
        logic [CLASS_BITS-1:0] pitch_set;
        logic [CLASS_BITS-1:0] attack_set;
    } t_chord;

    typedef struct packed {
        logic [ROOT_BITS-1:0] root;
        logic [QUAL_BITS-1:0] quality;
    } t_match;

    // Pitch class of a key number: the quotient by twelve comes from a
    // multiplication by 43/512, which is exact over the whole key range.
    function automatic logic [3:0] pitch_class(input logic [PITCH_BITS-1:0] pitch);
        logic [12:0] prod;
        logic [3:0]  quot;
        logic [6:0]  rem;
        prod = 13'(pitch) * 13'd43;
        quot = prod[12:9];
        rem  = pitch - (7'(quot) * 7'd12);
        return rem[3:0];
    endfunction

    // Number of pitch classes present in a set.
    function automatic logic [3:0] class_count(input logic [CLASS_BITS-1:0] set);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            n = n + 4'(set[i]);
        end
        return n;
    endfunction

    // Template search: the first template in quality order, at the lowest
    // rotation, wins. Scanning backwards lets the winner be written last.
    function automatic t_match match_chord(input logic [CLASS_BITS-1:0] set);
        t_match                res;
        logic [CLASS_BITS-1:0] rot;
        res.root    = '0;
        res.quality = QUAL_NONE;
        for (int k = NUM_TEMPLATES - 1; k >= 0; k--) begin
            for (int r = NUM_CLASSES - 1; r >= 0; r--) begin
                rot = 12'({set, set} >> r);
                if (rot == CHORD_TEMPLATES[k]) begin
                    res.root    = ROOT_BITS'(r);
                    res.quality = QUAL_BITS'(k + 1);
                end
            end
        end
        return res;
    endfunction

endpackage

// ===== src/mci_if.sv =====
// Note event channel.
interface mci_in_if
    import mci_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic [CHANNEL_BITS-1:0] channel;
    logic [PITCH_BITS-1:0]   pitch;
    logic [TICK_BITS-1:0]    tick;

    modport source (output valid, action, channel, pitch, tick, input ready);
    modport sink   (input valid, action, channel, pitch, tick, output ready);
endinterface

// Recognised chord channel.
interface mci_out_if
    import mci_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [TICK_BITS-1:0]  chord_tick;
    logic [CLASS_BITS-1:0] pitch_set;
    logic [CLASS_BITS-1:0] attack_set;
    logic [ROOT_BITS-1:0]  root;
    logic [QUAL_BITS-1:0]  quality;

    modport source (output valid, chord_tick, pitch_set, attack_set, root, quality,
                    input ready);
    modport sink   (input valid, chord_tick, pitch_set, attack_set, root, quality,
                    output ready);
endinterface

// ===== src/midi_chord_identifier_core.sv =====
// MIDI chord identifier. The block takes one note event per clock cycle while
// its input is ready and keeps a held-note count for each of the twelve pitch
// classes, together with the attack set and tick of the chord being gathered.
// A note-on at a later tick, or an end event, closes that chord; if its pitch
// set (the attacks, joined by the held classes while sustain is enabled) has
// three or more classes, one item leaves with the root and quality of the
// first matching template, or zero for both when none matches. Notes on the
// drum channel are ignored. A result passes from the count and chord state
// update into the closed chord register, then through the template search
// into the output register. The input stays ready as long as the output side
// drains, so a sustained rate of one event per cycle is kept. Sustain may be
// changed only while the block is idle.
module midi_chord_identifier_core
    import mci_pkg::*;
#(
    parameter int TICK_WIDTH  = TICK_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    mci_in_if.sink    i_in,
    mci_out_if.source o_out
);

    localparam int TICK_IN_W = (TICK_WIDTH < TICK_BITS) ? TICK_WIDTH : TICK_BITS;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_sustain;
    logic [COUNT_WIDTH-1:0] r_held_count [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] n_held_count [NUM_CLASSES];
    logic [CLASS_BITS-1:0]  r_attacks;
    logic [CLASS_BITS-1:0]  n_attacks;
    logic [TICK_WIDTH-1:0]  r_pending_tick;
    logic [TICK_WIDTH-1:0]  n_pending_tick;

    logic                   r_s1_valid;
    logic                   n_s1_valid;
    t_chord                 r_s1_chord;
    logic                   s1_ready;

    logic                   accept;
    logic                   emit;
    logic                   is_note;
    logic [3:0]             pc;
    logic [CLASS_BITS-1:0]  pc_bit;
    logic [CLASS_BITS-1:0]  held_set;
    logic [CLASS_BITS-1:0]  close_set;
    logic                   close_ok;
    logic [TICK_WIDTH-1:0]  ev_tick;
    logic [COUNT_WIDTH-1:0] cur_count;
    t_chord                 close_chord;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sustain <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_sustain <= i_cfg_wr_data;
        end
    end

    // The stage holding a closed chord frees up whenever the matcher takes it.
    assign i_in.ready = !r_s1_valid || s1_ready;
    assign accept     = i_in.valid && i_in.ready;

    // Decode the event.
    assign pc        = pitch_class(i_in.pitch);
    assign pc_bit    = CLASS_BITS'(1) << pc;
    assign is_note   = (i_in.channel != DRUM_CHANNEL);
    assign ev_tick   = TICK_WIDTH'(i_in.tick[TICK_IN_W-1:0]);
    assign cur_count = r_held_count[pc];

    // Held classes are taken before this event touches the counts.
    always_comb begin
        for (int i = 0; i < NUM_CLASSES; i++) begin
            held_set[i] = (r_held_count[i] != '0);
        end
    end

    assign close_set = r_attacks | (r_sustain ? held_set : '0);
    assign close_ok  = (class_count(close_set) >= 4'(MIN_CLASSES));

    assign close_chord.chord_tick = TICK_BITS'(r_pending_tick[TICK_IN_W-1:0]);
    assign close_chord.pitch_set  = close_set;
    assign close_chord.attack_set = r_attacks;

    // Chord and count state update for one event.
    always_comb begin
        n_held_count   = r_held_count;
        n_attacks      = r_attacks;
        n_pending_tick = r_pending_tick;
        emit           = 1'b0;
        case (i_in.action)
            ACT_END: begin
                emit      = close_ok;
                n_attacks = '0;
            end
            ACT_NOTE_ON: begin
                if (is_note) begin
                    if (ev_tick == r_pending_tick) begin
                        n_attacks = r_attacks | pc_bit;
                    end else if (ev_tick > r_pending_tick) begin
                        emit           = close_ok;
                        n_pending_tick = ev_tick;
                        n_attacks      = pc_bit;
                    end
                    if (cur_count != COUNT_MAX) begin
                        n_held_count[pc] = cur_count + 1'b1;
                    end
                end
            end
            ACT_NOTE_OFF: begin
                if (is_note && (cur_count != '0)) begin
                    n_held_count[pc] = cur_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_held_count[i] <= '0;
            end
            r_attacks      <= '0;
            r_pending_tick <= '0;
        end else if (accept) begin
            r_held_count   <= n_held_count;
            r_attacks      <= n_attacks;
            r_pending_tick <= n_pending_tick;
        end
    end

    // Closed chord register between the state update and the matcher.
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept && emit) begin
            n_s1_valid = 1'b1;
        end else if (s1_ready) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1_chord <= close_chord;
        end
    end

    mci_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (s1_ready),
        .i_chord (r_s1_chord),
        .o_out   (o_out)
    );

endmodule

// ===== src/mci_match.sv =====
module mci_match
    import mci_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_chord i_chord,
    mci_out_if.source o_out
);

    logic   r_valid;
    logic   n_valid;
    t_chord r_chord;
    t_match r_match;
    logic   load;

    // The result register takes a new chord when empty or being emptied.
    assign o_ready = !r_valid || o_out.ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Template search runs on the way into the result register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chord <= i_chord;
            r_match <= match_chord(i_chord.pitch_set);
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.chord_tick = r_chord.chord_tick;
    assign o_out.pitch_set  = r_chord.pitch_set;
    assign o_out.attack_set = r_chord.attack_set;
    assign o_out.root       = r_match.root;
    assign o_out.quality    = r_match.quality;

endmodule

// ===== src/mci_checker.sv =====
module mci_checker
    import mci_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [TICK_BITS-1:0]  i_chord_tick,
    input logic [CLASS_BITS-1:0] i_pitch_set,
    input logic [CLASS_BITS-1:0] i_attack_set,
    input logic [ROOT_BITS-1:0]  i_root,
    input logic [QUAL_BITS-1:0]  i_quality
);

    // A stalled result item stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_chord_tick) &&
        $stable(i_pitch_set) && $stable(i_attack_set) && $stable(i_root) &&
        $stable(i_quality))
        else $error("result item changed while stalled");

    // Only chords of three or more classes are reported.
    a_min_classes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $countones(i_pitch_set) >= MIN_CLASSES)
        else $error("chord with too few classes reported");

    // Every attacked class belongs to the pitch set.
    a_attack_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_attack_set & ~i_pitch_set) == '0)
        else $error("attack set not within pitch set");

    // An unrecognised chord carries a zero root.
    a_none_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_quality == QUAL_NONE) |-> i_root == '0)
        else $error("root given for unrecognised chord");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result item present after reset");

endmodule

bind midi_chord_identifier_core mci_checker u_mci_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_chord_tick (o_out.chord_tick),
    .i_pitch_set  (o_out.pitch_set),
    .i_attack_set (o_out.attack_set),
    .i_root       (o_out.root),
    .i_quality    (o_out.quality)
);
